### sv/assert_macros.svh
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property checked on every rising edge
`define CHK_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true
`define CHK_NEVER(lbl, expr, msg) \
    `CHK_PROP(lbl, !(expr), msg)

`endif

### sv/ngpp_pkg.sv
`timescale 1ns / 1ps
package ngpp_pkg;

    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_COMMA = 8'd44;
    localparam logic [7:0] CHAR_DOT   = 8'd46;

    // "$GPGGA", padded
    localparam logic [7:0] GGA_TAG [8] = '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41,
                                           8'h00, 8'h00};
    localparam logic [2:0] TAG_LEN = 3'd6;

    localparam logic [23:0] POW10 [8] = '{24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000,
                                          24'd100000, 24'd1000000, 24'd10000000};

    localparam logic [2:0] FIELD_TIME = 3'd1;
    localparam logic [2:0] FIELD_LAT  = 3'd2;
    localparam logic [2:0] FIELD_LON  = 3'd4;
    localparam logic [2:0] FIELD_MAX  = 3'd5;

    localparam logic [17:0] TIME_SAT_M1 = 18'd239999;
    localparam logic [17:0] TIME_SAT    = 18'd240000;
    localparam logic [17:0] COORD_SAT   = 18'd18100;

    localparam int QDEPTH = 4;

    localparam logic [1:0] ST_ACCEPT  = 2'd0;
    localparam logic [1:0] ST_DISCARD = 2'd1;
    localparam logic [1:0] ST_HALT    = 2'd2;

    // one finished line, integer and fraction parts kept apart
    typedef struct packed {
        logic        ok;
        logic [17:0] t;
        logic [14:0] lat_ip;
        logic [23:0] lat_f;
        logic [14:0] lon_ip;
        logic [23:0] lon_f;
    } fix_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

### sv/ngpp_front.sv
`timescale 1ns / 1ps
module ngpp_front
    import ngpp_pkg::*;
#(
    parameter int FRAC_DIGITS = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  byte_in,
    output logic        push,
    output fix_rec_t    rec
);

    logic [2:0]  fi_reg, fi_next;
    logic [2:0]  pos_reg, pos_next;
    logic        tok_reg, tok_next;
    logic        lv_reg, lv_next;
    logic [17:0] t_reg, t_next;
    logic [14:0] lat_ip_reg, lat_ip_next, lon_ip_reg, lon_ip_next;
    logic [23:0] lat_f_reg, lat_f_next, lon_f_reg, lon_f_next;
    logic        has_int_reg, has_int_next;
    logic [2:0]  fcnt_reg, fcnt_next;
    logic [1:0]  dot_reg, dot_next;

    logic        checked;
    logic        is_digit;
    logic [3:0]  dig;
    logic [21:0] tx;
    logic [17:0] ipx;
    logic [14:0] cur_ip, new_ip;
    logic [23:0] cur_f, new_f;
    logic [2:0]  pidx;
    logic        tok_close, lv_close;

    assign checked  = (fi_reg == FIELD_TIME) || (fi_reg == FIELD_LAT) || (fi_reg == FIELD_LON);
    assign is_digit = (byte_in >= 8'd48) && (byte_in <= 8'd57);
    assign dig      = 4'(byte_in - 8'd48);
    assign tx       = {4'd0, t_reg} * 22'd10 + 22'(dig);
    assign cur_ip   = (fi_reg == FIELD_LAT) ? lat_ip_reg : lon_ip_reg;
    assign cur_f    = (fi_reg == FIELD_LAT) ? lat_f_reg : lon_f_reg;
    assign ipx      = {3'd0, cur_ip} * 18'd10 + 18'(dig);
    assign pidx     = 3'(FRAC_DIGITS - 1) - fcnt_reg;

    // field close, shared by comma and line end
    always_comb
    begin
        tok_close = tok_reg;
        lv_close  = lv_reg;
        if (fi_reg == 3'd0)
        begin
            tok_close = tok_reg && (pos_reg == TAG_LEN);
        end
        else if (tok_reg && checked && !has_int_reg)
        begin
            lv_close = 1'b0;
        end
    end

    always_comb
    begin
        new_ip = cur_ip;
        new_f  = cur_f;
        if (dot_reg == 2'd0)
        begin
            new_ip = (ipx > COORD_SAT) ? 15'(COORD_SAT) : 15'(ipx);
        end
        else if (dot_reg == 2'd1 && fcnt_reg < 3'(FRAC_DIGITS))
        begin
            new_f = cur_f + 24'(dig) * POW10[pidx];
        end
    end

    always_comb
    begin
        fi_next      = fi_reg;
        pos_next     = pos_reg;
        tok_next     = tok_reg;
        lv_next      = lv_reg;
        t_next       = t_reg;
        lat_ip_next  = lat_ip_reg;
        lat_f_next   = lat_f_reg;
        lon_ip_next  = lon_ip_reg;
        lon_f_next   = lon_f_reg;
        has_int_next = has_int_reg;
        fcnt_next    = fcnt_reg;
        dot_next     = dot_reg;
        push         = 1'b0;
        rec.ok       = lv_close && (fi_reg >= FIELD_LON);
        rec.t        = t_reg;
        rec.lat_ip   = lat_ip_reg;
        rec.lat_f    = lat_f_reg;
        rec.lon_ip   = lon_ip_reg;
        rec.lon_f    = lon_f_reg;
        if (accept)
        begin
            if (byte_in == CHAR_LF)
            begin
                push         = tok_close;
                fi_next      = 3'd0;
                pos_next     = 3'd0;
                tok_next     = 1'b1;
                lv_next      = 1'b1;
                t_next       = '0;
                lat_ip_next  = '0;
                lat_f_next   = '0;
                lon_ip_next  = '0;
                lon_f_next   = '0;
                has_int_next = 1'b0;
                fcnt_next    = '0;
                dot_next     = '0;
            end
            else if (byte_in == CHAR_COMMA)
            begin
                tok_next     = tok_close;
                lv_next      = lv_close;
                if (fi_reg < FIELD_MAX)
                begin
                    fi_next = fi_reg + 3'd1;
                end
                has_int_next = 1'b0;
                fcnt_next    = '0;
                dot_next     = '0;
            end
            else if (fi_reg == 3'd0)
            begin
                if (tok_reg)
                begin
                    if (pos_reg < TAG_LEN && byte_in == GGA_TAG[pos_reg])
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                    else
                    begin
                        tok_next = 1'b0;
                    end
                end
            end
            else if (tok_reg && checked)
            begin
                if (is_digit)
                begin
                    if (fi_reg == FIELD_TIME)
                    begin
                        if (dot_reg == 2'd0)
                        begin
                            t_next = (tx > 22'(TIME_SAT_M1)) ? TIME_SAT : 18'(tx);
                        end
                    end
                    else if (fi_reg == FIELD_LAT)
                    begin
                        lat_ip_next = new_ip;
                        lat_f_next  = new_f;
                    end
                    else
                    begin
                        lon_ip_next = new_ip;
                        lon_f_next  = new_f;
                    end
                    if (dot_reg == 2'd1 && fcnt_reg < 3'(FRAC_DIGITS) && fi_reg != FIELD_TIME)
                    begin
                        fcnt_next = fcnt_reg + 3'd1;
                    end
                    if (dot_reg == 2'd0)
                    begin
                        has_int_next = 1'b1;
                    end
                end
                else if (byte_in == CHAR_DOT)
                begin
                    if (dot_reg < 2'd2)
                    begin
                        dot_next = dot_reg + 2'd1;
                    end
                end
                else
                begin
                    lv_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fi_reg      <= '0;
            pos_reg     <= '0;
            tok_reg     <= 1'b1;
            lv_reg      <= 1'b1;
            t_reg       <= '0;
            lat_ip_reg  <= '0;
            lat_f_reg   <= '0;
            lon_ip_reg  <= '0;
            lon_f_reg   <= '0;
            has_int_reg <= 1'b0;
            fcnt_reg    <= '0;
            dot_reg     <= '0;
        end
        else
        begin
            fi_reg      <= fi_next;
            pos_reg     <= pos_next;
            tok_reg     <= tok_next;
            lv_reg      <= lv_next;
            t_reg       <= t_next;
            lat_ip_reg  <= lat_ip_next;
            lat_f_reg   <= lat_f_next;
            lon_ip_reg  <= lon_ip_next;
            lon_f_reg   <= lon_f_next;
            has_int_reg <= has_int_next;
            fcnt_reg    <= fcnt_next;
            dot_reg     <= dot_next;
        end
    end

endmodule

### sv/ngpp_queue.sv
`timescale 1ns / 1ps
module ngpp_queue
    import ngpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  fix_rec_t    push_data,
    input  logic        pop,
    output fix_rec_t    head,
    output queue_stat_t stat
);

    localparam int PW = $clog2(QDEPTH);

    fix_rec_t          mem_reg [QDEPTH];
    logic [PW-1:0]     wp_reg, rp_reg;
    logic [PW:0]       cnt_reg;
    logic              do_push, do_pop;

    assign stat.full  = (cnt_reg == (PW+1)'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (do_pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end

endmodule

### sv/ngpp_back.sv
`timescale 1ns / 1ps
module ngpp_back
    import ngpp_pkg::*;
#(
    parameter int FRAC_DIGITS = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  fix_rec_t    head,
    input  queue_stat_t qstat,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,
    output logic [1:0]  m_tuser
);

    localparam logic [23:0] PF    = POW10[7 - FRAC_DIGITS];
    localparam logic [18:0] M_H   = 19'd429497;
    localparam logic [12:0] M_DEG = 13'd5243;
    localparam logic [14:0] M_MN  = 15'd20972;
    localparam logic [28:0] M_15  = 29'd286331154;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_DIV  = 6'b000010,
        B_REM  = 6'b000100,
        B_MUL  = 6'b001000,
        B_FIN  = 6'b010000,
        B_OUT  = 6'b100000
    } bstate_t;

    bstate_t     st_reg, st_next;
    fix_rec_t    rec_reg;
    logic [4:0]  h_reg;
    logic [7:0]  lad_reg, lod_reg;
    logic [13:0] r_reg;
    logic [6:0]  lam_reg, lom_reg, mn_reg, sec_reg;
    logic [13:0] lat_t_reg, lon_t_reg;
    logic [27:0] lay_reg, loy_reg;
    logic [23:0] laq_reg, loq_reg;
    logic [30:0] lae_reg, loe_reg;
    logic        lbad_reg, obad_reg;
    logic [16:0] last_reg;
    logic        halted_reg;
    logic        ov_reg;
    logic [79:0] od_reg;
    logic [1:0]  os_reg;

    logic [36:0] hp;
    logic [27:0] ladp, lodp;
    logic [28:0] mnp;
    logic [56:0] laqp, loqp;
    logic [16:0] ts;
    logic        tok;
    logic        out_free;
    logic [1:0]  status;

    assign hp       = {19'd0, head.t} * 37'(M_H);
    assign ladp     = {13'd0, rec_reg.lat_ip} * 28'(M_DEG);
    assign lodp     = {13'd0, rec_reg.lon_ip} * 28'(M_DEG);
    assign mnp      = {15'd0, r_reg} * 29'(M_MN);
    assign laqp     = {29'd0, lay_reg} * 57'(M_15);
    assign loqp     = {29'd0, loy_reg} * 57'(M_15);
    assign ts       = 17'(h_reg) * 17'd3600 + 17'(mn_reg) * 17'd60 + 17'(sec_reg);
    assign tok      = (h_reg <= 5'd23) && (mn_reg <= 7'd59) && (sec_reg <= 7'd59);
    assign out_free = !ov_reg || m_tready;
    assign pop      = (st_reg == B_IDLE) && !qstat.empty;

    always_comb
    begin
        if (!rec_reg.ok || !tok || lbad_reg || obad_reg)
        begin
            status = ST_DISCARD;
        end
        else if (ts <= last_reg)
        begin
            status = ST_HALT;
        end
        else
        begin
            status = ST_ACCEPT;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            B_IDLE: if (!qstat.empty && !halted_reg) st_next = B_DIV;
            B_DIV:  st_next = B_REM;
            B_REM:  st_next = B_MUL;
            B_MUL:  st_next = B_FIN;
            B_FIN:  st_next = B_OUT;
            B_OUT:  if (out_free) st_next = B_IDLE;
            default: st_next = B_IDLE;
        endcase
    end

    // datapath, one step of the conversion per state
    always_ff @(posedge clk)
    begin
        if (st_reg == B_IDLE)
        begin
            rec_reg <= head;
            h_reg   <= hp[36:32];
        end
        if (st_reg == B_DIV)
        begin
            lad_reg <= 8'(ladp[27:19]);
            lod_reg <= 8'(lodp[27:19]);
        end
        if (st_reg == B_REM)
        begin
            r_reg   <= 14'(rec_reg.t - 18'(h_reg) * 18'd10000);
            lam_reg <= 7'(rec_reg.lat_ip - 15'(lad_reg) * 15'd100);
            lom_reg <= 7'(rec_reg.lon_ip - 15'(lod_reg) * 15'd100);
        end
        if (st_reg == B_MUL)
        begin
            mn_reg    <= 7'(mnp[28:21]);
            lat_t_reg <= 14'(lad_reg) * 14'd60 + 14'(lam_reg);
            lon_t_reg <= 14'(lod_reg) * 14'd60 + 14'(lom_reg);
            lay_reg   <= 28'((32'(lam_reg) * 32'd10000000
                              + 32'(rec_reg.lat_f) * 32'(PF)) >> 2);
            loy_reg   <= 28'((32'(lom_reg) * 32'd10000000
                              + 32'(rec_reg.lon_f) * 32'(PF)) >> 2);
        end
        if (st_reg == B_FIN)
        begin
            sec_reg  <= 7'(r_reg - 14'(mn_reg) * 14'd100);
            laq_reg  <= laqp[55:32];
            loq_reg  <= loqp[55:32];
            lae_reg  <= 31'(lad_reg) * 31'd10000000;
            loe_reg  <= 31'(lod_reg) * 31'd10000000;
            lbad_reg <= (lat_t_reg > 14'd10800)
                        || (lat_t_reg == 14'd10800 && rec_reg.lat_f != '0);
            obad_reg <= (lon_t_reg > 14'd10800)
                        || (lon_t_reg == 14'd10800 && rec_reg.lon_f != '0);
        end
        if (st_reg == B_OUT && out_free)
        begin
            os_reg <= status;
            if (status == ST_DISCARD)
            begin
                od_reg <= '0;
            end
            else
            begin
                od_reg <= {1'b0, loe_reg + 31'(loq_reg), lae_reg + 31'(laq_reg), ts};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= B_IDLE;
            last_reg   <= '0;
            halted_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == B_OUT && out_free)
            begin
                ov_reg <= 1'b1;
                if (status == ST_ACCEPT)
                begin
                    last_reg <= ts;
                end
                if (status == ST_HALT)
                begin
                    halted_reg <= 1'b1;
                end
            end
            else if (m_tready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = os_reg;

endmodule

### sv/nmea_gga_position_parser_unit.sv
`timescale 1ns / 1ps
// channel  | signals                      | word
// ---------+------------------------------+-------------------------------------------
// s (in)   | s_tvalid s_tready s_tdata    | line_byte[7:0]
// m (out)  | m_tvalid m_tready m_tdata    | time_seconds, latitude_e7, longitude_e7
//          | m_tuser                      | status[1:0]
//
// one byte per cycle into the front parser; s_tready drops only while the
// four-entry line queue is full
// each finished $GPGGA line steps through back states IDLE, DIV, REM, MUL, FIN
// and OUT, its step sequence of reciprocal multiplies, plus any wait on m_tready
// asynchronous active-low reset clears parser, queue, last time and halt flag
// after a time-not-increasing result, bytes are still taken and queued lines dropped
module nmea_gga_position_parser_unit
    import ngpp_pkg::*;
#(
    parameter int FRAC_DIGITS = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // line_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // time_seconds[16:0], latitude_e7[47:17],
                                    // longitude_e7[78:48], zero[79]
    output logic [1:0]  m_tuser     // status[1:0]
);

`include "assert_macros.svh"

    logic        accept;
    logic        push;
    logic        pop;
    fix_rec_t    rec;
    fix_rec_t    head;
    queue_stat_t qstat;

    // input stalls only when no queue slot is left for a line end
    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;

    // front: character classification, field split, digit accumulation
    ngpp_front #(.FRAC_DIGITS(FRAC_DIGITS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .byte_in (s_tdata),
        .push    (push),
        .rec     (rec)
    );

    // queue decouples byte parsing from conversion
    ngpp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (rec),
        .pop       (pop),
        .head      (head),
        .stat      (qstat)
    );

    // back: range checks, degree conversion, time order and halt
    ngpp_back #(.FRAC_DIGITS(FRAC_DIGITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .qstat    (qstat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `CHK_PROP(a_status_code, m_tvalid |-> (m_tuser == ST_ACCEPT || m_tuser == ST_DISCARD || m_tuser == ST_HALT), "bad status code")
    `CHK_PROP(a_discard_zero, (m_tvalid && m_tuser == ST_DISCARD) |-> (m_tdata == '0), "discard word not zero")
    `CHK_NEVER(a_queue_flags, qstat.full && qstat.empty, "queue full and empty")
    `CHK_PROP(a_halt_last, (m_tvalid && m_tready && m_tuser == ST_HALT) |=> !m_tvalid, "word after halt")

endmodule
